### hw/rtl/scp_pkg.sv
// Shared widths, types and wide-multiply helpers for the segment closest-point pipeline.
`timescale 1ns / 1ps

package scp_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int DIFF_W        = COORD_WIDTH + 1;        // end - start
  localparam int PROD_W        = 2 * DIFF_W;             // one coordinate product
  localparam int DOT_W         = PROD_W + 2;             // sum of three products
  localparam int LO_W          = DOT_W / 2;              // low half of a split operand
  localparam int HI_W          = DOT_W - LO_W;           // signed high half
  localparam int WIDE_W        = 2 * DOT_W + 1;          // a*e - b*b and b*f - c*e
  localparam int ALT_W         = DOT_W + 1;              // -c and b - c
  localparam int BS_W          = DOT_W + FRAC_W + 1;     // b * s
  localparam int TNUM_W        = DOT_W + FRACTION_BITS + 3;
  localparam int FP_W          = DIFF_W + FRAC_W + 1;    // d1 * s

  localparam logic [FRAC_W-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [DOT_W-1:0]       dot_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;
  typedef logic signed [ALT_W-1:0]       alt_t;
  typedef logic        [FRAC_W-1:0]      frac_t;
  typedef logic signed [BS_W-1:0]        bs_t;
  typedef logic signed [TNUM_W-1:0]      tnum_t;
  typedef logic signed [FP_W-1:0]        fp_t;

  // partial products of a split DOT_W x DOT_W signed multiply
  typedef struct packed {
    logic signed [2*HI_W-1:0]    hh;
    logic signed [HI_W+LO_W:0]   hl;
    logic signed [HI_W+LO_W:0]   lh;
    logic        [2*LO_W-1:0]    ll;
  } pp_t;

  function automatic pp_t pp_mul(dot_t x, dot_t y);
    logic signed [HI_W-1:0] xh;
    logic signed [HI_W-1:0] yh;
    logic        [LO_W-1:0] xl;
    logic        [LO_W-1:0] yl;
    pp_t p;
    xh = x[DOT_W-1:LO_W];
    yh = y[DOT_W-1:LO_W];
    xl = x[LO_W-1:0];
    yl = y[LO_W-1:0];
    p.hh = xh * yh;
    p.hl = xh * $signed({1'b0, yl});
    p.lh = $signed({1'b0, xl}) * yh;
    p.ll = xl * yl;
    return p;
  endfunction

  function automatic wide_t pp_sum(pp_t p);
    wide_t hh_w;
    wide_t hl_w;
    wide_t lh_w;
    wide_t ll_w;
    hh_w = wide_t'($signed(p.hh));
    hl_w = wide_t'($signed(p.hl));
    lh_w = wide_t'($signed(p.lh));
    ll_w = wide_t'($signed({1'b0, p.ll}));
    return (hh_w <<< (2 * LO_W)) + (hl_w <<< LO_W) + (lh_w <<< LO_W) + ll_w;
  endfunction

  // clamped fraction from the division flags and quotient
  function automatic frac_t frac_of(logic zero, logic sat, logic [FRACTION_BITS-1:0] q);
    frac_t r;
    if (zero) begin
      r = '0;
    end else if (sat) begin
      r = ONE;
    end else begin
      r = {1'b0, q};
    end
    return r;
  endfunction

endpackage

### hw/rtl/segment_closest_point.sv
// Top level: pipelined closest point on a first 3D segment to a second segment.
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | request in| in_valid / in_stall  | first/second start/end x,y,z (Q12.12)
//  out     | result out| out_valid / out_stall| closest_x/y/z (Q12.12), segment_fraction
//
//  One request enters per cycle while in_stall is low.
//  The pipeline is 16 one-bit restoring division stages plus 10 stages of dot
//  products, split 52x52 multiplies, the t test and the final scale.
//  Reset (rst, synchronous) clears only the valid bits; payload registers are not reset.
//  A stalled result holds the whole pipeline: in_stall follows out_valid && out_stall,
//  so nothing is dropped or repeated.

module segment_closest_point (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  scp_pkg::coord_t       first_start_x,
  input  scp_pkg::coord_t       first_start_y,
  input  scp_pkg::coord_t       first_start_z,
  input  scp_pkg::coord_t       first_end_x,
  input  scp_pkg::coord_t       first_end_y,
  input  scp_pkg::coord_t       first_end_z,
  input  scp_pkg::coord_t       second_start_x,
  input  scp_pkg::coord_t       second_start_y,
  input  scp_pkg::coord_t       second_start_z,
  input  scp_pkg::coord_t       second_end_x,
  input  scp_pkg::coord_t       second_end_y,
  input  scp_pkg::coord_t       second_end_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output scp_pkg::coord_t       closest_x,
  output scp_pkg::coord_t       closest_y,
  output scp_pkg::coord_t       closest_z,
  output scp_pkg::frac_t        segment_fraction
);

  localparam int FB = scp_pkg::FRACTION_BITS;

  // global advance: the output register is free or is being drained
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  scp_pkg::coord_t p1_in [3];
  scp_pkg::coord_t q1_in [3];
  scp_pkg::coord_t p2_in [3];
  scp_pkg::coord_t q2_in [3];

  always_comb begin
    p1_in = '{first_start_x, first_start_y, first_start_z};
    q1_in = '{first_end_x, first_end_y, first_end_z};
    p2_in = '{second_start_x, second_start_y, second_start_z};
    q2_in = '{second_end_x, second_end_y, second_end_z};
  end

  // ---------------- stage A: direction vectors and offset ----------------
  logic            a_v;
  scp_pkg::coord_t a_p1 [3];
  scp_pkg::diff_t  a_d1 [3];
  scp_pkg::diff_t  a_d2 [3];
  scp_pkg::diff_t  a_r  [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_p1[i] <= p1_in[i];
        a_d1[i] <= scp_pkg::diff_t'(q1_in[i]) - scp_pkg::diff_t'(p1_in[i]);
        a_d2[i] <= scp_pkg::diff_t'(q2_in[i]) - scp_pkg::diff_t'(p2_in[i]);
        a_r[i]  <= scp_pkg::diff_t'(p1_in[i]) - scp_pkg::diff_t'(p2_in[i]);
      end
    end
  end

  // ---------------- stage B: coordinate products ----------------
  logic            b_v;
  scp_pkg::coord_t b_p1 [3];
  scp_pkg::diff_t  b_d1 [3];
  scp_pkg::prod_t  b_aa [3];
  scp_pkg::prod_t  b_bb [3];
  scp_pkg::prod_t  b_cc [3];
  scp_pkg::prod_t  b_ee [3];
  scp_pkg::prod_t  b_ff [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_p1[i] <= a_p1[i];
        b_d1[i] <= a_d1[i];
        b_aa[i] <= a_d1[i] * a_d1[i];
        b_bb[i] <= a_d1[i] * a_d2[i];
        b_cc[i] <= a_d1[i] * a_r[i];
        b_ee[i] <= a_d2[i] * a_d2[i];
        b_ff[i] <= a_d2[i] * a_r[i];
      end
    end
  end

  // ---------------- stage C: dot products a, b, c, e, f ----------------
  logic            c_v;
  scp_pkg::coord_t c_p1 [3];
  scp_pkg::diff_t  c_d1 [3];
  scp_pkg::dot_t   c_a, c_b, c_c, c_e, c_f;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_p1 <= b_p1;
      c_d1 <= b_d1;
      c_a  <= scp_pkg::dot_t'(b_aa[0]) + scp_pkg::dot_t'(b_aa[1]) + scp_pkg::dot_t'(b_aa[2]);
      c_b  <= scp_pkg::dot_t'(b_bb[0]) + scp_pkg::dot_t'(b_bb[1]) + scp_pkg::dot_t'(b_bb[2]);
      c_c  <= scp_pkg::dot_t'(b_cc[0]) + scp_pkg::dot_t'(b_cc[1]) + scp_pkg::dot_t'(b_cc[2]);
      c_e  <= scp_pkg::dot_t'(b_ee[0]) + scp_pkg::dot_t'(b_ee[1]) + scp_pkg::dot_t'(b_ee[2]);
      c_f  <= scp_pkg::dot_t'(b_ff[0]) + scp_pkg::dot_t'(b_ff[1]) + scp_pkg::dot_t'(b_ff[2]);
    end
  end

  // ---------------- stage D: split partial products ----------------
  logic            d_v;
  scp_pkg::coord_t d_p1 [3];
  scp_pkg::diff_t  d_d1 [3];
  scp_pkg::dot_t   d_a, d_b, d_c, d_e, d_f;
  scp_pkg::pp_t    d_ae, d_bb, d_bf, d_ce;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_p1 <= c_p1;
      d_d1 <= c_d1;
      d_a  <= c_a;
      d_b  <= c_b;
      d_c  <= c_c;
      d_e  <= c_e;
      d_f  <= c_f;
      d_ae <= scp_pkg::pp_mul(c_a, c_e);
      d_bb <= scp_pkg::pp_mul(c_b, c_b);
      d_bf <= scp_pkg::pp_mul(c_b, c_f);
      d_ce <= scp_pkg::pp_mul(c_c, c_e);
    end
  end

  // ---------------- stage E: denominator and numerators ----------------
  logic            e_v;
  scp_pkg::coord_t e_p1 [3];
  scp_pkg::diff_t  e_d1 [3];
  scp_pkg::dot_t   e_b, e_e, e_f;
  scp_pkg::wide_t  e_den, e_num;
  scp_pkg::alt_t   e_nc, e_nbc, e_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_p1  <= d_p1;
      e_d1  <= d_d1;
      e_b   <= d_b;
      e_e   <= d_e;
      e_f   <= d_f;
      e_den <= scp_pkg::pp_sum(d_ae) - scp_pkg::pp_sum(d_bb);
      e_num <= scp_pkg::pp_sum(d_bf) - scp_pkg::pp_sum(d_ce);
      e_nc  <= -scp_pkg::alt_t'(d_c);
      e_nbc <= scp_pkg::alt_t'(d_b) - scp_pkg::alt_t'(d_c);
      e_a   <= scp_pkg::alt_t'(d_a);
    end
  end

  // ---------------- division pipeline ----------------
  // index 0 holds the clamp flags and the starting remainder, each later index one
  // quotient bit. Three divisions run side by side: num/den, -c/a and (b-c)/a.
  logic                       dv   [0:FB];
  logic [scp_pkg::WIDE_W-1:0] mr   [0:FB];
  logic [scp_pkg::WIDE_W-1:0] md   [0:FB];
  logic [FB-1:0]              mq   [0:FB];
  logic                       mz   [0:FB];
  logic                       mo   [0:FB];
  logic [scp_pkg::ALT_W-1:0]  ad   [0:FB];
  logic [scp_pkg::ALT_W-1:0]  lr   [0:FB];
  logic [FB-1:0]              lq   [0:FB];
  logic                       lz   [0:FB];
  logic                       lo   [0:FB];
  logic [scp_pkg::ALT_W-1:0]  hr   [0:FB];
  logic [FB-1:0]              hq   [0:FB];
  logic                       hz   [0:FB];
  logic                       ho   [0:FB];
  scp_pkg::dot_t              sb   [0:FB];
  scp_pkg::dot_t              se   [0:FB];
  scp_pkg::dot_t              sf   [0:FB];
  scp_pkg::coord_t            sp1  [0:FB][3];
  scp_pkg::diff_t             sd1  [0:FB][3];

  logic den_le0, a_le0;
  assign den_le0 = e_den[scp_pkg::WIDE_W-1] || (e_den == '0);
  assign a_le0   = e_a[scp_pkg::ALT_W-1] || (e_a == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      mr[0]  <= e_num;
      md[0]  <= e_den;
      mq[0]  <= '0;
      mz[0]  <= den_le0 || e_num[scp_pkg::WIDE_W-1] || (e_num == '0);
      mo[0]  <= e_num >= e_den;
      ad[0]  <= e_a;
      lr[0]  <= e_nc;
      lq[0]  <= '0;
      lz[0]  <= a_le0 || e_nc[scp_pkg::ALT_W-1] || (e_nc == '0);
      lo[0]  <= e_nc >= e_a;
      hr[0]  <= e_nbc;
      hq[0]  <= '0;
      hz[0]  <= a_le0 || e_nbc[scp_pkg::ALT_W-1] || (e_nbc == '0);
      ho[0]  <= e_nbc >= e_a;
      sb[0]  <= e_b;
      se[0]  <= e_e;
      sf[0]  <= e_f;
      sp1[0] <= e_p1;
      sd1[0] <= e_d1;
    end
  end

  for (genvar k = 0; k < FB; k++) begin : g_div
    logic [scp_pkg::WIDE_W:0] m_sh;
    logic [scp_pkg::ALT_W:0]  l_sh;
    logic [scp_pkg::ALT_W:0]  h_sh;
    logic                     m_ge, l_ge, h_ge;

    assign m_sh = {mr[k], 1'b0};
    assign l_sh = {lr[k], 1'b0};
    assign h_sh = {hr[k], 1'b0};
    assign m_ge = m_sh >= {1'b0, md[k]};
    assign l_ge = l_sh >= {1'b0, ad[k]};
    assign h_ge = h_sh >= {1'b0, ad[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mr[k+1]  <= m_ge ? scp_pkg::WIDE_W'(m_sh - {1'b0, md[k]})
                         : m_sh[scp_pkg::WIDE_W-1:0];
        lr[k+1]  <= l_ge ? scp_pkg::ALT_W'(l_sh - {1'b0, ad[k]})
                         : l_sh[scp_pkg::ALT_W-1:0];
        hr[k+1]  <= h_ge ? scp_pkg::ALT_W'(h_sh - {1'b0, ad[k]})
                         : h_sh[scp_pkg::ALT_W-1:0];
        mq[k+1]  <= {mq[k][FB-2:0], m_ge};
        lq[k+1]  <= {lq[k][FB-2:0], l_ge};
        hq[k+1]  <= {hq[k][FB-2:0], h_ge};
        md[k+1]  <= md[k];
        ad[k+1]  <= ad[k];
        mz[k+1]  <= mz[k];
        mo[k+1]  <= mo[k];
        lz[k+1]  <= lz[k];
        lo[k+1]  <= lo[k];
        hz[k+1]  <= hz[k];
        ho[k+1]  <= ho[k];
        sb[k+1]  <= sb[k];
        se[k+1]  <= se[k];
        sf[k+1]  <= sf[k];
        sp1[k+1] <= sp1[k];
        sd1[k+1] <= sd1[k];
      end
    end
  end

  // ---------------- stage G: b * s for the t test ----------------
  scp_pkg::frac_t s_first, s_low, s_high;
  assign s_first = scp_pkg::frac_of(mz[FB], mo[FB], mq[FB]);
  assign s_low   = scp_pkg::frac_of(lz[FB], lo[FB], lq[FB]);
  assign s_high  = scp_pkg::frac_of(hz[FB], ho[FB], hq[FB]);

  logic            g_v;
  scp_pkg::bs_t    g_bs;
  scp_pkg::frac_t  g_s1, g_slo, g_shi;
  scp_pkg::dot_t   g_e, g_f;
  scp_pkg::coord_t g_p1 [3];
  scp_pkg::diff_t  g_d1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      g_bs  <= sb[FB] * $signed({1'b0, s_first});
      g_s1  <= s_first;
      g_slo <= s_low;
      g_shi <= s_high;
      g_e   <= se[FB];
      g_f   <= sf[FB];
      g_p1  <= sp1[FB];
      g_d1  <= sd1[FB];
    end
  end

  // ---------------- stage H: t test and choice of s ----------------
  // t < 0 picks the start of the second segment, t > 1 its end; a zero-length second
  // segment keeps the first estimate.
  scp_pkg::tnum_t tnum, tlim;
  scp_pkg::frac_t s_sel;

  always_comb begin
    tnum = scp_pkg::tnum_t'(g_bs) + (scp_pkg::tnum_t'(g_f) <<< FB);
    tlim = scp_pkg::tnum_t'(g_e) <<< FB;
    if (g_e == '0) begin
      s_sel = g_s1;
    end else if (tnum[scp_pkg::TNUM_W-1]) begin
      s_sel = g_slo;
    end else if (tnum > tlim) begin
      s_sel = g_shi;
    end else begin
      s_sel = g_s1;
    end
  end

  logic            h_v;
  scp_pkg::frac_t  h_s;
  scp_pkg::coord_t h_p1 [3];
  scp_pkg::diff_t  h_d1 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      h_s  <= s_sel;
      h_p1 <= g_p1;
      h_d1 <= g_d1;
    end
  end

  // ---------------- stage I: d1 * s ----------------
  logic            i_v;
  scp_pkg::frac_t  i_s;
  scp_pkg::coord_t i_p1   [3];
  scp_pkg::fp_t    i_prod [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      i_s  <= h_s;
      i_p1 <= h_p1;
      for (int i = 0; i < 3; i++) begin
        i_prod[i] <= h_d1[i] * $signed({1'b0, h_s});
      end
    end
  end

  // ---------------- stage J: output register ----------------
  // floor(d1*s / ONE) is the arithmetic shift; only the low coordinate bits survive
  always_ff @(posedge clk) begin
    if (adv) begin
      closest_x        <= i_p1[0] + i_prod[0][FB +: scp_pkg::COORD_WIDTH];
      closest_y        <= i_p1[1] + i_prod[1][FB +: scp_pkg::COORD_WIDTH];
      closest_z        <= i_p1[2] + i_prod[2][FB +: scp_pkg::COORD_WIDTH];
      segment_fraction <= i_s;
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      e_v       <= 1'b0;
      dv[0]     <= 1'b0;
      g_v       <= 1'b0;
      h_v       <= 1'b0;
      i_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_v       <= in_valid;
      b_v       <= a_v;
      c_v       <= b_v;
      d_v       <= c_v;
      e_v       <= d_v;
      dv[0]     <= e_v;
      g_v       <= dv[FB];
      h_v       <= g_v;
      i_v       <= h_v;
      out_valid <= i_v;
    end
  end

endmodule

### hw/rtl/scp_checker.sv
// Port-level checker for segment_closest_point, bound to the top level.
`timescale 1ns / 1ps

module scp_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input scp_pkg::coord_t closest_x,
  input scp_pkg::coord_t closest_y,
  input scp_pkg::coord_t closest_z,
  input scp_pkg::frac_t  segment_fraction
);

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(closest_x) && $stable(closest_y)
      && $stable(closest_z) && $stable(segment_fraction))
    else $error("stalled result changed");

  // the fraction is clamped to one
  a_frac: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> segment_fraction <= scp_pkg::ONE)
    else $error("fraction above one");

  // the pipeline back-pressures only when the output is held
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind segment_closest_point scp_checker u_scp_checker (.*);
